### rtl/hgp_pkg.sv
// ----------------------------------------------------------------------------
// hgp_pkg
// shared types, codes and literal tables of the get request parser
// ----------------------------------------------------------------------------
package hgp_pkg;

	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_PTR_W = 2;
	localparam int unsigned Q_CNT_W = 3;

	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_SP    = 8'd32;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_COLON = 8'd58;
	localparam logic [7:0] CH_NUL   = 8'd0;

	localparam logic [3:0] METHOD_LEN  = 4'd4;
	localparam logic [3:0] VERSION_LEN = 4'd10;
	localparam logic [3:0] CONN_LEN    = 4'd10;

	localparam logic [1:0] CFG_PATH_LIMIT  = 2'd0;
	localparam logic [1:0] CFG_VALUE_LIMIT = 2'd1;

	typedef enum logic [2:0] {
		K_NONE   = 3'd0,
		K_PATH   = 3'd1,
		K_VALUE  = 3'd2,
		K_ACCEPT = 3'd3,
		K_REJECT = 3'd4
	} kind_t;

	typedef enum logic [8:0] {
		PH_METHOD  = 9'b000000001,
		PH_PATH    = 9'b000000010,
		PH_VERSION = 9'b000000100,
		PH_LINE    = 9'b000001000,
		PH_BLANK   = 9'b000010000,
		PH_SKIP    = 9'b000100000,
		PH_SPACE   = 9'b001000000,
		PH_VALUE   = 9'b010000000,
		PH_DONE    = 9'b100000000
	} phase_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} push_t;

	function automatic logic [7:0] lit_method(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0:    c = 8'h47;
			2'd1:    c = 8'h45;
			2'd2:    c = 8'h54;
			default: c = 8'h20;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] lit_version(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = 8'h48;
			4'd1:    c = 8'h54;
			4'd2:    c = 8'h54;
			4'd3:    c = 8'h50;
			4'd4:    c = 8'h2f;
			4'd5:    c = 8'h31;
			4'd6:    c = 8'h2e;
			4'd7:    c = 8'h31;
			4'd8:    c = 8'h0d;
			4'd9:    c = 8'h0a;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] lit_conn(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = 8'h63;
			4'd1:    c = 8'h6f;
			4'd2:    c = 8'h6e;
			4'd3:    c = 8'h6e;
			4'd4:    c = 8'h65;
			4'd5:    c = 8'h63;
			4'd6:    c = 8'h74;
			4'd7:    c = 8'h69;
			4'd8:    c = 8'h6f;
			4'd9:    c = 8'h6e;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5a) ? 8'(b + 8'd32) : b;
	endfunction

endpackage

### rtl/hgp_parser.sv
// ----------------------------------------------------------------------------
// hgp_parser
// per-byte parser state machine, produces up to two result words per byte
// ----------------------------------------------------------------------------
module hgp_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic [7:0]       data_byte,
	input  logic             start_of_request,
	input  logic [7:0]       path_limit,
	input  logic [7:0]       value_limit,
	output hgp_pkg::push_t   push
);

	hgp_pkg::phase_t phase_q, n_ph;
	logic [3:0]      mp_q, n_mp;
	logic [7:0]      ec_q, n_ec;
	logic            cr_q, n_cr;

	hgp_pkg::kind_t  rk [2];
	logic [7:0]      rb [2];
	logic [1:0]      cnt;

	always_comb begin
		hgp_pkg::phase_t ph;
		logic            rej;
		logic            do_val;
		logic [7:0]      b;

		b      = data_byte;
		ph     = start_of_request ? hgp_pkg::PH_METHOD : phase_q;
		n_mp   = start_of_request ? 4'd0 : mp_q;
		n_ec   = start_of_request ? 8'd0 : ec_q;
		n_cr   = start_of_request ? 1'b0 : cr_q;
		n_ph   = ph;
		rej    = 1'b0;
		do_val = 1'b0;
		cnt    = 2'd0;
		rk[0]  = hgp_pkg::K_NONE;
		rk[1]  = hgp_pkg::K_NONE;
		rb[0]  = 8'd0;
		rb[1]  = 8'd0;

		case (ph)
			hgp_pkg::PH_METHOD: begin
				if (n_mp < hgp_pkg::METHOD_LEN && b == hgp_pkg::lit_method(n_mp[1:0])) begin
					n_mp = 4'(n_mp + 4'd1);
					if (n_mp == hgp_pkg::METHOD_LEN) begin
						n_ph = hgp_pkg::PH_PATH;
						n_mp = 4'd0;
						n_ec = 8'd0;
					end
				end else begin
					rej = 1'b1;
				end
			end
			hgp_pkg::PH_PATH: begin
				if (b == hgp_pkg::CH_NUL) begin
					rej = 1'b1;
				end else if (b == hgp_pkg::CH_SP) begin
					if (n_mp == 4'd0) begin
						rej = 1'b1;
					end else begin
						n_ph = hgp_pkg::PH_VERSION;
						n_mp = 4'd0;
					end
				end else begin
					n_mp = 4'd1;
					if (n_ec < path_limit) begin
						n_ec  = 8'(n_ec + 8'd1);
						rk[0] = hgp_pkg::K_PATH;
						rb[0] = b;
						cnt   = 2'd1;
					end
				end
			end
			hgp_pkg::PH_VERSION: begin
				if (n_mp < hgp_pkg::VERSION_LEN && b == hgp_pkg::lit_version(n_mp)) begin
					n_mp = 4'(n_mp + 4'd1);
					if (n_mp == hgp_pkg::VERSION_LEN) begin
						n_ph = hgp_pkg::PH_LINE;
						n_mp = 4'd0;
					end
				end else begin
					rej = 1'b1;
				end
			end
			hgp_pkg::PH_LINE: begin
				if (b == hgp_pkg::CH_NUL) begin
					rej = 1'b1;
				end else if (n_mp >= hgp_pkg::CONN_LEN) begin
					if (b == hgp_pkg::CH_COLON) begin
						n_ph = hgp_pkg::PH_SPACE;
						n_ec = 8'd0;
						n_cr = 1'b0;
					end else begin
						rej = 1'b1;
					end
				end else if (n_mp == 4'd0 && b == hgp_pkg::CH_CR) begin
					n_ph = hgp_pkg::PH_BLANK;
				end else if (hgp_pkg::to_lower(b) == hgp_pkg::lit_conn(n_mp)) begin
					n_mp = 4'(n_mp + 4'd1);
				end else begin
					n_ph = hgp_pkg::PH_SKIP;
					n_cr = (b == hgp_pkg::CH_CR);
				end
			end
			hgp_pkg::PH_BLANK: begin
				if (b == hgp_pkg::CH_NUL) begin
					rej = 1'b1;
				end else if (b == hgp_pkg::CH_LF) begin
					n_ph  = hgp_pkg::PH_DONE;
					rk[0] = hgp_pkg::K_ACCEPT;
					rb[0] = 8'd0;
					cnt   = 2'd1;
				end else begin
					n_ph = hgp_pkg::PH_SKIP;
					n_cr = (b == hgp_pkg::CH_CR);
				end
			end
			hgp_pkg::PH_SKIP: begin
				if (b == hgp_pkg::CH_NUL) begin
					rej = 1'b1;
				end else if (n_cr && b == hgp_pkg::CH_LF) begin
					n_cr = 1'b0;
					n_ph = hgp_pkg::PH_LINE;
					n_mp = 4'd0;
				end else begin
					n_cr = (b == hgp_pkg::CH_CR);
				end
			end
			hgp_pkg::PH_SPACE: begin
				if (b == hgp_pkg::CH_NUL) begin
					rej = 1'b1;
				end else if (b != hgp_pkg::CH_SP && b != hgp_pkg::CH_TAB) begin
					do_val = 1'b1;
				end
			end
			hgp_pkg::PH_VALUE: begin
				if (b == hgp_pkg::CH_NUL) begin
					rej = 1'b1;
				end else begin
					do_val = 1'b1;
				end
			end
			hgp_pkg::PH_DONE: begin
				n_ph = hgp_pkg::PH_DONE;
			end
			default: begin
				n_ph = hgp_pkg::PH_DONE;
			end
		endcase

		// value byte, with a held carriage return and the end of the header line
		if (do_val) begin
			n_ph = hgp_pkg::PH_VALUE;
			if (n_cr && b == hgp_pkg::CH_LF) begin
				n_cr = 1'b0;
				n_ph = hgp_pkg::PH_LINE;
				n_mp = 4'd0;
				n_ec = 8'd0;
			end else begin
				if (n_cr) begin
					n_cr = 1'b0;
					if (n_ec < value_limit) begin
						n_ec  = 8'(n_ec + 8'd1);
						rk[0] = hgp_pkg::K_VALUE;
						rb[0] = hgp_pkg::CH_CR;
						cnt   = 2'd1;
					end
				end
				if (b == hgp_pkg::CH_CR) begin
					n_cr = 1'b1;
				end else if (n_ec < value_limit) begin
					n_ec       = 8'(n_ec + 8'd1);
					rk[cnt[0]] = hgp_pkg::K_VALUE;
					rb[cnt[0]] = b;
					cnt        = 2'(cnt + 2'd1);
				end
			end
		end

		if (rej) begin
			n_ph  = hgp_pkg::PH_DONE;
			n_cr  = 1'b0;
			rk[0] = hgp_pkg::K_REJECT;
			rb[0] = 8'd0;
			cnt   = 2'd1;
		end
	end

	always_comb begin
		push.cnt     = fire ? cnt : 2'd0;
		push.r0.kind = rk[0];
		push.r0.data = rb[0];
		push.r0.last = (cnt == 2'd1);
		push.r1.kind = rk[1];
		push.r1.data = rb[1];
		push.r1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hgp_pkg::PH_METHOD;
			mp_q    <= 4'd0;
			ec_q    <= 8'd0;
			cr_q    <= 1'b0;
		end else if (fire) begin
			phase_q <= n_ph;
			mp_q    <= n_mp;
			ec_q    <= n_ec;
			cr_q    <= n_cr;
		end
	end

endmodule

### rtl/hgp_out_queue.sv
// ----------------------------------------------------------------------------
// hgp_out_queue
// result queue, takes up to two words per cycle and hands out one
// ----------------------------------------------------------------------------
module hgp_out_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  hgp_pkg::push_t    push,
	output logic              room,
	output logic              m_tvalid,
	input  logic              m_tready,
	output hgp_pkg::result_t  head
);

	hgp_pkg::result_t                entry_q [hgp_pkg::Q_DEPTH];
	logic [hgp_pkg::Q_PTR_W-1:0]     wr_q, rd_q;
	logic [hgp_pkg::Q_CNT_W-1:0]     count_q;
	logic                            pop;
	logic [hgp_pkg::Q_PTR_W-1:0]     wr_nx;

	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (count_q != '0);
	assign room     = (count_q <= hgp_pkg::Q_CNT_W'(hgp_pkg::Q_DEPTH - 2));
	assign head     = entry_q[rd_q];
	assign wr_nx    = hgp_pkg::Q_PTR_W'(wr_q + 1'b1);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			entry_q[wr_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			entry_q[wr_nx] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= hgp_pkg::Q_PTR_W'(wr_q + push.cnt);
			if (pop) begin
				rd_q <= hgp_pkg::Q_PTR_W'(rd_q + 1'b1);
			end
			count_q <= hgp_pkg::Q_CNT_W'(count_q + push.cnt - {2'b00, pop});
		end
	end

endmodule

### rtl/http_get_request_parser.sv
// ----------------------------------------------------------------------------
// http_get_request_parser
// byte stream parser for the request line and connection header of a get
// ----------------------------------------------------------------------------
// s_tdata carries one request byte a word, s_tuser marks the first byte of a
// new request. each accepted byte updates the parser state in the same cycle
// and pushes zero, one or two result words into a four-word output queue.
// m_tdata is the path or value byte, m_tuser the result kind, m_tlast marks
// the final word caused by one input byte. m_* is read from the queue.
// throughput: one byte per cycle while the receiver takes one word per
// cycle and no byte yields two words; s_tready drops when fewer than two
// queue slots are free.
// cfg_* writes path_limit (index 0) or value_limit (index 1); cfg_ready is
// always high, other indexes are ignored. write only while idle.
// reset: parser waits for a method, queue empty, both limits 199.
// a stalled receiver fills the queue and then holds off the input side.
// ----------------------------------------------------------------------------
module http_get_request_parser (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // data_byte
	input  logic       s_tuser,   // start_of_request
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte
	output logic [2:0] m_tuser,   // out_kind
	output logic       m_tlast,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	logic              fire;
	logic              room;
	logic [7:0]        path_limit_q, value_limit_q;
	hgp_pkg::push_t    push;
	hgp_pkg::result_t  head;

	assign s_tready  = room;
	assign fire      = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			path_limit_q  <= 8'd199;
			value_limit_q <= 8'd199;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hgp_pkg::CFG_PATH_LIMIT:  path_limit_q  <= cfg_data;
				hgp_pkg::CFG_VALUE_LIMIT: value_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	hgp_parser u_parser (
		.clk              (clk),
		.arst_n           (arst_n),
		.fire             (fire),
		.data_byte        (s_tdata),
		.start_of_request (s_tuser),
		.path_limit       (path_limit_q),
		.value_limit      (value_limit_q),
		.push             (push)
	);

	hgp_out_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.head     (head)
	);

	assign m_tdata = head.data;
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

	a_push_needs_fire: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |-> push.cnt == 2'd0)
		else $error("results pushed without an accepted byte");

	a_pair_is_value: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt == 2'd2 |-> push.r0.kind == hgp_pkg::K_VALUE
			&& push.r1.kind == hgp_pkg::K_VALUE && !push.r0.last)
		else $error("two results from one byte that are not a value pair");

	a_reject_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0 && push.r0.kind == hgp_pkg::K_REJECT) |-> push.cnt == 2'd1)
		else $error("reject pushed together with another result");

	a_out_kind_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == hgp_pkg::K_PATH || m_tuser == hgp_pkg::K_VALUE
			|| m_tuser == hgp_pkg::K_ACCEPT || m_tuser == hgp_pkg::K_REJECT))
		else $error("output word with an empty kind");

endmodule
